// ===== sv/assert_macros.svh =====
// Assertion helpers included by two_level_page_table_manager.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tlpt_pkg.sv =====
package tlpt_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned ENTRIES = 1024;

  localparam logic [31:0]      DIR_EMPTY    = 32'h0000_0002;
  localparam logic [OFF_W-1:0] PAGE_PRESENT = 12'h001;
  localparam logic [19:0]      BASE_RESET   = 20'h00100;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_DIR     = 3'd1,
    ST_NO_PTE     = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_MAPPED     = 3'd4,
    ST_NO_FRAME   = 3'd5
  } status_e;

  typedef struct packed {
    logic [IDX_W-1:0] frame;
    logic [31:0]      word;
  } dir_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    dir_entry_t       data;
  } dir_wr_t;

endpackage

// ===== sv/tlpt_if.sv =====
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] virt_addr;
  logic [31:0] map_addr;
  logic [11:0] page_flags;

  modport source (output valid, func, virt_addr, map_addr, page_flags, input ready);
  modport sink   (input valid, func, virt_addr, map_addr, page_flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_out;
  logic [2:0]  status;

  modport source (output valid, phys_out, status, input ready);
  modport sink   (input valid, phys_out, status, output ready);
endinterface

// ===== sv/tlpt_dir.sv =====
module tlpt_dir (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tlpt_pkg::IDX_W-1:0]    rd_addr_i,
  input  tlpt_pkg::dir_wr_t             wr_i,
  output tlpt_pkg::dir_entry_t          rd_data_o,
  output logic                          ready_o
);

  tlpt_pkg::dir_entry_t mem [tlpt_pkg::ENTRIES];

  logic [tlpt_pkg::IDX_W-1:0] init_q;
  logic                       busy_q;

  logic                       we;
  logic [tlpt_pkg::IDX_W-1:0] waddr;
  tlpt_pkg::dir_entry_t       wdata;

  // After reset every entry is swept to the empty value, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      init_q <= init_q + 1'b1;
      if (init_q == tlpt_pkg::IDX_W'(tlpt_pkg::ENTRIES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy_q) begin
      we    = 1'b1;
      waddr = init_q;
      wdata = '{frame: '0, word: tlpt_pkg::DIR_EMPTY};
    end else begin
      we    = wr_i.en;
      waddr = wr_i.addr;
      wdata = wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign ready_o = !busy_q;

endmodule

// ===== sv/two_level_page_table_manager.sv =====
// Channel  Dir  Word contents
// req_i    in   func, virt_addr, map_addr, page_flags
// rsp_o    out  phys_out, status
// cfg      in   frame_base (write enable and data, no read-back)
//
// A translate, or a map into an existing table, has its result registered after accept:
// the directory read, then the table read, each registered in a synchronous memory.
// A misaligned map answers in the cycle after it is accepted.
// A map that creates a table sweeps all 1024 entries of the new frame.
// After reset the directory is cleared before the first word is taken.
// A word is taken only when idle and the result register is empty or being emptied.
`include "assert_macros.svh"

module two_level_page_table_manager #(
  parameter int unsigned FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpt_req_if.sink    req_i,
  tlpt_rsp_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW  = $clog2(FRAMES + 1);
  localparam int unsigned TAW = (FRAMES > 1) ? $clog2(FRAMES * tlpt_pkg::ENTRIES)
                                             : tlpt_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIR,
    S_TBL,
    S_CLR
  } state_e;

  state_e state_q;

  logic [19:0]                base_q;
  logic [CW-1:0]              cnt_q;
  logic [FW-1:0]              frame_q;
  logic [tlpt_pkg::IDX_W-1:0] clr_q;

  logic                       func_q;
  logic [tlpt_pkg::IDX_W-1:0] di_q;
  logic [tlpt_pkg::IDX_W-1:0] ti_q;
  logic [tlpt_pkg::OFF_W-1:0] off_q;
  logic [31:0]                pte_q;

  logic        rsp_valid_q;
  logic [31:0] rsp_phys_q;
  logic [2:0]  rsp_status_q;
  logic        rsp_load;

  tlpt_pkg::dir_entry_t dir_rdata;
  tlpt_pkg::dir_wr_t    dir_wr;
  logic                 dir_ready;

  logic [31:0]    tbl_mem [FRAMES * tlpt_pkg::ENTRIES];
  logic [31:0]    tbl_rdata_q;
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr;
  logic [TAW-1:0] tbl_raddr;
  logic [31:0]    tbl_wdata;

  logic accept;
  logic misaligned;
  logic frames_full;

  tlpt_dir u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(req_i.virt_addr[31:22]),
    .wr_i     (dir_wr),
    .rd_data_o(dir_rdata),
    .ready_o  (dir_ready)
  );

  assign req_i.ready = dir_ready && (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign misaligned  = (req_i.virt_addr[11:0] != '0) || (req_i.map_addr[11:0] != '0);
  assign frames_full = (cnt_q == CW'(FRAMES));

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.phys_out = rsp_phys_q;
  assign rsp_o.status   = rsp_status_q;

  always_comb begin
    dir_wr.en         = (state_q == S_DIR) && func_q && !dir_rdata.word[0] && !frames_full;
    dir_wr.addr       = di_q;
    dir_wr.data.frame = tlpt_pkg::IDX_W'(cnt_q);
    dir_wr.data.word  = {base_q + 20'(cnt_q), tlpt_pkg::PAGE_PRESENT};
  end

  always_comb begin
    case (state_q)
      S_IDLE:  rsp_load = accept && req_i.func && misaligned;
      S_DIR:   rsp_load = !dir_rdata.word[0] && (!func_q || frames_full);
      S_CLR:   rsp_load = (clr_q == tlpt_pkg::IDX_W'(tlpt_pkg::ENTRIES - 1));
      S_TBL:   rsp_load = 1'b1;
      default: rsp_load = 1'b0;
    endcase
  end

  always_comb begin
    tbl_raddr = TAW'({FW'(dir_rdata.frame), ti_q});
    tbl_we    = 1'b0;
    tbl_waddr = TAW'({frame_q, ti_q});
    tbl_wdata = pte_q;
    case (state_q)
      S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = TAW'({frame_q, clr_q});
        tbl_wdata = (clr_q == ti_q) ? pte_q : '0;
      end
      S_TBL: begin
        tbl_we = func_q && !tbl_rdata_q[0];
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= tlpt_pkg::BASE_RESET;
      cnt_q        <= '0;
      frame_q      <= '0;
      clr_q        <= '0;
      func_q       <= 1'b0;
      di_q         <= '0;
      ti_q         <= '0;
      off_q        <= '0;
      pte_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_phys_q   <= '0;
      rsp_status_q <= tlpt_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i[31:12];
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q <= req_i.func;
            di_q   <= req_i.virt_addr[31:22];
            ti_q   <= req_i.virt_addr[21:12];
            off_q  <= req_i.virt_addr[11:0];
            pte_q  <= {req_i.map_addr[31:12], req_i.page_flags[11:1], 1'b1};
            if (req_i.func && misaligned) begin
              rsp_phys_q   <= '0;
              rsp_status_q <= tlpt_pkg::ST_MISALIGNED;
            end else begin
              state_q <= S_DIR;
            end
          end
        end
        S_DIR: begin
          if (dir_rdata.word[0]) begin
            frame_q <= FW'(dir_rdata.frame);
            state_q <= S_TBL;
          end else if (!func_q) begin
            rsp_phys_q   <= '0;
            rsp_status_q <= tlpt_pkg::ST_NO_DIR;
            state_q      <= S_IDLE;
          end else if (frames_full) begin
            rsp_phys_q   <= '0;
            rsp_status_q <= tlpt_pkg::ST_NO_FRAME;
            state_q      <= S_IDLE;
          end else begin
            frame_q <= FW'(cnt_q);
            cnt_q   <= cnt_q + 1'b1;
            clr_q   <= '0;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tlpt_pkg::IDX_W'(tlpt_pkg::ENTRIES - 1)) begin
            rsp_phys_q   <= '0;
            rsp_status_q <= tlpt_pkg::ST_OK;
            state_q      <= S_IDLE;
          end
        end
        S_TBL: begin
          state_q <= S_IDLE;
          if (!func_q) begin
            if (tbl_rdata_q[0]) begin
              rsp_phys_q   <= {tbl_rdata_q[31:12], off_q};
              rsp_status_q <= tlpt_pkg::ST_OK;
            end else begin
              rsp_phys_q   <= '0;
              rsp_status_q <= tlpt_pkg::ST_NO_PTE;
            end
          end else begin
            rsp_phys_q   <= '0;
            rsp_status_q <= tbl_rdata_q[0] ? tlpt_pkg::ST_MAPPED : tlpt_pkg::ST_OK;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(FRAMES), "frame count overflow")
  `ASSERT_SAME(a_slot_free, clk_i, rst_ni, accept, !rsp_valid_q || rsp_o.ready, "result slot busy")
  `ASSERT_SAME(a_init_block, clk_i, rst_ni, !dir_ready, !req_i.ready, "accept during clear")
  `ASSERT_SAME(a_fail_zero, clk_i, rst_ni, rsp_valid_q && (rsp_status_q != tlpt_pkg::ST_OK),
               rsp_phys_q == '0, "failed result carries an address")
  `ASSERT_NEXT(a_one_result, clk_i, rst_ni, accept && !(req_i.func && misaligned),
               !rsp_valid_q, "result before the walk")

endmodule
